/* hdl/sfk_pkg.sv */
// Package for the squarefree kernel trial-division core.
// Holds the default width, controller state type and controller/datapath command and status structs.
// No dependencies.
package sfk_pkg;

    // Default operand width
    localparam int VALUE_BITS_DEF = 31;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_INIT,
        S_DIV_RUN,
        S_EVAL,
        S_MUL_D,
        S_MUL_FIN,
        S_FINISH
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;           // capture input, product = 1, divisor = 2
        logic div_start;      // start serial divide rest / divisor
        logic div_step;       // one restoring divide step
        logic strip;          // rest = quotient, flip parity
        logic next_div;       // advance divisor (2 -> 3, else +2), clear parity
        logic mul_start_d;    // start product * divisor
        logic mul_start_rest; // start product * remaining value
        logic mul_step;       // one shift-add step
        logic mul_commit;     // product = accumulator
        logic out_kernel;     // present product as result
        logic out_zero;       // present zero-input flag
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic in_zero;     // input value is zero
        logic div_last;    // last divide step in progress
        logic rem_zero;    // divisor divides remaining value
        logic bound_fail;  // odd divisor exceeds rest / divisor on first trial
        logic par;         // odd count of current divisor
        logic mplier_zero; // multiplier fully consumed
        logic rest_gt1;    // remaining value above one
    } t_dp_sts;

endpackage

/* hdl/squarefree_kernel_trial_division_core.sv */
// Top level of the squarefree kernel trial-division core.
// Joins sfk_ctrl and sfk_dpath; depends on sfk_pkg.
//
//  channel  | signals                                  | handshake
//  ---------+------------------------------------------+------------------------------
//  command  | start, i_value_in                        | transfer when start && !busy
//  result   | o_valid, o_kernel_out, o_bad_input       | one-cycle strobe, no stall
//
// Each trial divide runs the serial restoring divider, one bit per cycle; each odd-count
// prime adds one multiply cycle per multiplier bit plus a commit, and a leftover prime
// a final state to present the result. A 31-bit prime takes about 23000 trials.
// Zero input: the result strobes in the cycle after the transfer and busy never rises.
// Reset is synchronous, active low, and returns the controller to idle.
// The result strobe lasts one cycle and cannot be held off by the receiver.
module squarefree_kernel_trial_division_core #(
    parameter int VALUE_BITS = sfk_pkg::VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [VALUE_BITS-1:0] i_value_in,
    output logic                  o_valid,
    output logic [VALUE_BITS-1:0] o_kernel_out,
    output logic                  o_bad_input
);
    import sfk_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencer
    sfk_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // Divider, multiplier and result registers
    sfk_dpath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_value_in   (i_value_in),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_valid      (o_valid),
        .o_kernel_out (o_kernel_out),
        .o_bad_input  (o_bad_input)
    );

endmodule

/* hdl/sfk_ctrl.sv */
// Controller state machine for the squarefree kernel core.
// Sequences divide, strip, multiply and result steps; depends on sfk_pkg.
module sfk_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  sfk_pkg::t_dp_sts i_sts,
    output sfk_pkg::t_dp_cmd o_cmd,
    output logic            o_busy
);
    import sfk_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_sts.in_zero) begin
                        o_cmd.out_zero = 1'b1;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = S_DIV_INIT;
                    end
                end
            end
            S_DIV_INIT: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV_RUN;
            end
            S_DIV_RUN: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                priority if (i_sts.bound_fail) begin
                    // trial loop over: leftover above one is a single prime
                    if (i_sts.rest_gt1) begin
                        o_cmd.mul_start_rest = 1'b1;
                        n_state              = S_MUL_FIN;
                    end else begin
                        o_cmd.out_kernel = 1'b1;
                        n_state          = S_IDLE;
                    end
                end else if (i_sts.rem_zero) begin
                    o_cmd.strip = 1'b1;
                    n_state     = S_DIV_INIT;
                end else if (i_sts.par) begin
                    o_cmd.mul_start_d = 1'b1;
                    n_state           = S_MUL_D;
                end else begin
                    o_cmd.next_div = 1'b1;
                    n_state        = S_DIV_INIT;
                end
            end
            S_MUL_D: begin
                if (i_sts.mplier_zero) begin
                    o_cmd.mul_commit = 1'b1;
                    o_cmd.next_div   = 1'b1;
                    n_state          = S_DIV_INIT;
                end else begin
                    o_cmd.mul_step = 1'b1;
                end
            end
            S_MUL_FIN: begin
                if (i_sts.mplier_zero) begin
                    o_cmd.mul_commit = 1'b1;
                    n_state          = S_FINISH;
                end else begin
                    o_cmd.mul_step = 1'b1;
                end
            end
            S_FINISH: begin
                o_cmd.out_kernel = 1'b1;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    // Returning to idle always issues a result
    a_idle_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && n_state == S_IDLE) |-> o_cmd.out_kernel)
        else $error("controller returned to idle without a result");

    // Divide runs only after it was started
    a_div_after_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_RUN) |-> ($past(r_state) == S_DIV_INIT || $past(r_state) == S_DIV_RUN))
        else $error("divide step without start");

endmodule

/* hdl/sfk_dpath.sv */
// Datapath for the squarefree kernel core: serial restoring divider,
// shift-add multiplier, trial state and result registers. Depends on sfk_pkg.
module sfk_dpath #(
    parameter int VALUE_BITS = sfk_pkg::VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [VALUE_BITS-1:0] i_value_in,
    input  sfk_pkg::t_dp_cmd      i_cmd,
    output sfk_pkg::t_dp_sts      o_sts,
    output logic                  o_valid,
    output logic [VALUE_BITS-1:0] o_kernel_out,
    output logic                  o_bad_input
);
    import sfk_pkg::*;

    // Divisor never passes sqrt of the value plus two
    localparam int DIV_BITS = VALUE_BITS / 2 + 2;
    localparam int CNT_BITS = $clog2(VALUE_BITS);
    localparam logic [DIV_BITS-1:0] DIV_TWO   = DIV_BITS'(2);
    localparam logic [DIV_BITS-1:0] DIV_THREE = DIV_BITS'(3);

    logic [VALUE_BITS-1:0] r_rest;
    logic [DIV_BITS-1:0]   r_div;
    logic                  r_par;
    logic                  r_first;
    logic [VALUE_BITS-1:0] r_prod;
    logic [VALUE_BITS-1:0] r_quo;
    logic [DIV_BITS-1:0]   r_rem;
    logic [CNT_BITS-1:0]   r_cnt;
    logic [VALUE_BITS-1:0] r_mcand;
    logic [VALUE_BITS-1:0] r_mplier;
    logic [VALUE_BITS-1:0] r_acc;
    logic                  r_valid;
    logic [VALUE_BITS-1:0] r_kernel;
    logic                  r_bad;

    logic [DIV_BITS:0]     rem_sh;
    logic                  rem_ge;
    logic [DIV_BITS:0]     rem_sub;

    // One restoring divide step
    assign rem_sh  = {r_rem, r_quo[VALUE_BITS-1]};
    assign rem_ge  = (rem_sh >= {1'b0, r_div});
    assign rem_sub = rem_sh - {1'b0, r_div};

    // Trial state: remaining value, divisor, parity, product
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rest  <= i_value_in;
            r_div   <= DIV_TWO;
            r_par   <= 1'b0;
            r_first <= 1'b1;
            r_prod  <= VALUE_BITS'(1);
        end else begin
            if (i_cmd.strip) begin
                r_rest  <= r_quo;
                r_par   <= ~r_par;
                r_first <= 1'b0;
            end
            if (i_cmd.next_div) begin
                r_div   <= (r_div == DIV_TWO) ? DIV_THREE : r_div + DIV_TWO;
                r_par   <= 1'b0;
                r_first <= 1'b1;
            end
            if (i_cmd.mul_commit) begin
                r_prod <= r_acc;
            end
        end
    end

    // Serial divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_quo <= r_rest;
            r_rem <= '0;
            r_cnt <= CNT_BITS'(VALUE_BITS - 1);
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[VALUE_BITS-2:0], rem_ge};
            r_rem <= rem_ge ? rem_sub[DIV_BITS-1:0] : rem_sh[DIV_BITS-1:0];
            r_cnt <= r_cnt - CNT_BITS'(1);
        end
    end

    // Shift-add multiplier, product kept modulo the value width
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start_d || i_cmd.mul_start_rest) begin
            r_mcand  <= r_prod;
            r_mplier <= i_cmd.mul_start_d ? VALUE_BITS'(r_div) : r_rest;
            r_acc    <= '0;
        end else if (i_cmd.mul_step) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= {r_mcand[VALUE_BITS-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[VALUE_BITS-1:1]};
        end
    end

    // Result registers and strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.out_kernel || i_cmd.out_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_zero) begin
            r_kernel <= '0;
            r_bad    <= 1'b1;
        end else if (i_cmd.out_kernel) begin
            r_kernel <= r_prod;
            r_bad    <= 1'b0;
        end
    end

    // Status to controller
    always_comb begin
        o_sts.in_zero     = (i_value_in == '0);
        o_sts.div_last    = (r_cnt == '0);
        o_sts.rem_zero    = (r_rem == '0);
        o_sts.bound_fail  = (r_div != DIV_TWO) && r_first && (VALUE_BITS'(r_div) > r_quo);
        o_sts.par         = r_par;
        o_sts.mplier_zero = (r_mplier == '0);
        o_sts.rest_gt1    = (r_rest > VALUE_BITS'(1));
    end

    assign o_valid      = r_valid;
    assign o_kernel_out = r_kernel;
    assign o_bad_input  = r_bad;

    // Remainder stays below divisor after every divide step
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.div_step) |-> (r_rem < r_div))
        else $error("divider remainder not below divisor");

    // Zero-input flag always comes with a zero kernel
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_bad) |-> (r_kernel == '0))
        else $error("flagged result with nonzero kernel");

endmodule

/* verif/squarefree_kernel_trial_division_core_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for squarefree_kernel_trial_division_core.
// Drives start/value transfers from a queue and checks every result strobe against a
// trial-division kernel predictor. Depends on sfk_pkg and the core.
module squarefree_kernel_trial_division_core_test;

    import sfk_pkg::*;

    localparam int VB = VALUE_BITS_DEF;
    localparam longint unsigned VALUE_MASK = (64'd1 << VB) - 1;
    localparam int N_DIRECTED = 25;
    localparam int N_RANDOM = 75;
    // random values are shrunk until their estimated factoring cost is within this cap
    localparam longint RANDOM_COST_CAP = 6000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed {
        logic [VB-1:0] kernel;
        logic          bad;
    } t_kernel_res;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start = 1'b0;
    logic [VB-1:0] i_value_in = '0;
    logic          busy;
    logic          o_valid;
    logic [VB-1:0] o_kernel_out;
    logic          o_bad_input;

    logic [VB-1:0] value_q[$];        // values waiting to be transferred
    t_kernel_res   kernel_due_q[$];   // predicted results, oldest first
    int            n_items = 0;
    int            n_accepted = 0;
    int            mismatches = 0;

    // driver state
    logic          item_held = 1'b0;
    logic [VB-1:0] held_value = '0;
    logic          stall;
    longint        drv_cost;

    longint unsigned directed_vals[N_DIRECTED] = '{
        0, 1, 2, 3, 4, 8, 9, 12, 27, 36, 72, 0, 0,
        994009,             // 997 squared
        223092870,          // product of the first nine primes
        1162261467,         // 3^19
        1220703125,         // 5^13
        1977326743,         // 7^11
        64'h7FFF_FFFE, 64'h4000_0000, 64'h5555_5555, 64'h2AAA_AAAA,
        6000018,            // 2 * 3 * large prime left over after the loop
        64'h7FFF_FFFF,      // full-width prime, slowest case
        0                   // zero arriving while the core is still busy
    };

    int unsigned small_primes[16] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41,
                                      43, 47, 53};

    squarefree_kernel_trial_division_core #(
        .VALUE_BITS(VB)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_value_in  (i_value_in),
        .o_valid     (o_valid),
        .o_kernel_out(o_kernel_out),
        .o_bad_input (o_bad_input)
    );

    always #5 i_clk = ~i_clk;

    // Kernel of m by trial division: 2 first, then odd d while d*d <= rest.
    // cost is a rough cycle count for the serial divide/multiply datapath.
    function automatic t_kernel_res squarefree_kernel(input logic [VB-1:0] m,
                                                      output longint cost);
        longint unsigned rest;
        longint unsigned prod;
        longint unsigned d;
        bit              odd;
        t_kernel_res     r;
        cost = 2;
        r.kernel = '0;
        r.bad = 1'b1;
        if (m == '0)
            return r;
        rest = m;
        prod = 1;
        d = 2;
        // divisor 2 is always tried; odd divisors only while under the bound
        while (d == 2 || d <= rest / d) begin
            odd = 1'b0;
            cost += VB + 2;
            while (rest % d == 0) begin
                rest = rest / d;
                odd = ~odd;
                cost += VB + 2;
            end
            if (odd) begin
                prod = (prod * d) & VALUE_MASK;
                cost += VB;
            end
            d = (d == 2) ? 3 : d + 2;
        end
        // leftover above one is a prime seen once
        if (rest > 1) begin
            prod = (prod * rest) & VALUE_MASK;
            cost += VB;
        end
        r.kernel = prod[VB-1:0];
        r.bad = 1'b0;
        return r;
    endfunction

    task automatic report_failure(input string msg);
        if (mismatches < 10)
            $display("ERROR: %s", msg);
        mismatches++;
    endtask

    // Driver: present queued values; each cycle there is a chance of dropping start.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                kernel_due_q.insert(kernel_due_q.size(),
                                    squarefree_kernel(i_value_in, drv_cost));
                n_accepted++;
                item_held = 1'b0;
            end
            if (!item_held && value_q.size() > 0) begin
                held_value = value_q.pop_front();
                item_held = 1'b1;
            end
            // no idling for a stretch of transfers in the middle of the run
            stall = !(n_accepted >= 40 && n_accepted < 70) && ($urandom_range(0, 99) < 10);
            start <= item_held && !stall;
            i_value_in <= held_value;
        end
    end

    // Monitor: every strobe must match the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (kernel_due_q.size() == 0) begin
                report_failure($sformatf("unexpected result kernel=%0d bad=%0b",
                                         o_kernel_out, o_bad_input));
            end else begin
                if (o_kernel_out !== kernel_due_q[0].kernel)
                    report_failure($sformatf("kernel_out expected %0d, got %0d",
                                             kernel_due_q[0].kernel, o_kernel_out));
                if (o_bad_input !== kernel_due_q[0].bad)
                    report_failure($sformatf("bad_input expected %0b, got %0b",
                                             kernel_due_q[0].bad, o_bad_input));
                void'(kernel_due_q.pop_front());
            end
        end
    end

    initial begin
        longint unsigned v;
        longint          cost;
        longint          est_total;
        longint          cycle_limit;
        longint          cycle_cnt;
        int              i;
        int              pick;
        int              reps;
        int unsigned     p;

        est_total = 0;
        cycle_cnt = 0;

        // directed values first
        for (i = 0; i < N_DIRECTED; i++) begin
            v = directed_vals[i] & VALUE_MASK;
            void'(squarefree_kernel(v[VB-1:0], cost));
            est_total += cost + 8;
            value_q.insert(value_q.size(), v[VB-1:0]);
        end

        // random mix: zero, smooth numbers, two-factor products and masked or full-width randoms
        for (i = 0; i < N_RANDOM; i++) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                v = 0;
            end else if (pick <= 8) begin
                v = 1;
                reps = $urandom_range(1, 12);
                repeat (reps) begin
                    p = small_primes[$urandom_range(0, 15)];
                    if (v * p <= VALUE_MASK)
                        v = v * p;
                end
                // sometimes shift up to reach the top bit
                if ($urandom_range(0, 1))
                    while (v * 2 <= VALUE_MASK)
                        v = v * 2;
            end else if (pick <= 12) begin
                v = longint'($urandom_range(1, 1000)) * $urandom_range(2, 65535);
            end else if (pick <= 16) begin
                v = $urandom & ((64'd1 << $urandom_range(1, VB)) - 1);
            end else begin
                v = $urandom & VALUE_MASK;
            end
            void'(squarefree_kernel(v[VB-1:0], cost));
            while (cost > RANDOM_COST_CAP) begin
                v = v >> 1;
                void'(squarefree_kernel(v[VB-1:0], cost));
            end
            est_total += cost + 8;
            value_q.insert(value_q.size(), v[VB-1:0]);
        end
        n_items = value_q.size();
        cycle_limit = 4 * est_total + 50000;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!(n_accepted == n_items && kernel_due_q.size() == 0)
               && cycle_cnt < cycle_limit) begin
            @(posedge i_clk);
            cycle_cnt++;
        end

        if (cycle_cnt >= cycle_limit) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, kernel_due_q.size());
            $display("squarefree_kernel_trial_division_core verification failed");
        end else begin
            repeat (DRAIN_CYCLES) @(posedge i_clk);
            if (mismatches == 0 && kernel_due_q.size() == 0)
                $display("squarefree_kernel_trial_division_core verification clean");
            else
                $display("squarefree_kernel_trial_division_core verification failed");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/sfk_pkg.sv
hdl/sfk_ctrl.sv
hdl/sfk_dpath.sv
hdl/squarefree_kernel_trial_division_core.sv
verif/squarefree_kernel_trial_division_core_test.sv
